// ----- rtl/arm_pkg.sv -----
// Shared types, constants, S-box table and AES round functions for the AES-round MAC engine.
`timescale 1ns / 1ps
`default_nettype none
package arm_pkg;

  localparam int MEM_DEPTH = 69;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Layout of the 128-bit state memory.
  localparam logic [ADDR_W-1:0] ADDR_MK = ADDR_W'(0);   // master key schedule, 11 entries
  localparam logic [ADDR_W-1:0] ADDR_IW = ADDR_W'(11);  // initial state words, 9 entries
  localparam logic [ADDR_W-1:0] ADDR_FS = ADDR_W'(20);  // final subkeys, 18 entries
  localparam logic [ADDR_W-1:0] ADDR_NK = ADDR_W'(38);  // nonce key schedule, 11 entries
  localparam logic [ADDR_W-1:0] ADDR_TK = ADDR_W'(49);  // tag key schedule, 11 entries
  localparam logic [ADDR_W-1:0] ADDR_AS = ADDR_W'(60);  // running state words, 9 entries

  localparam int N_WORDS = 9;
  localparam int N_SUBKEYS = 18;
  localparam int LAST_ROUND = 10;
  localparam int N_BLANK = 4;
  localparam int BLOCK_BYTES = 64;

  localparam logic REG_KEY_LOW = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [127:0]      wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // ShiftRows, SubBytes, optional MixColumns, then the key add. Byte b sits at bits 8b+7..8b.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        t[c*4+rw] = SBOX[s[8*((((c+rw)&3)*4)+rw) +: 8]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        t[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = t[i] ^ k[8*i +: 8];
    end
    aes_round = r;
  endfunction

  // One step of the AES-128 key schedule.
  function automatic logic [127:0] key_step(input logic [127:0] p, input logic [7:0] rcon);
    logic [7:0] tmp [4];
    logic [7:0] q [16];
    logic [127:0] r;
    tmp[0] = SBOX[p[8*13 +: 8]] ^ rcon;
    tmp[1] = SBOX[p[8*14 +: 8]];
    tmp[2] = SBOX[p[8*15 +: 8]];
    tmp[3] = SBOX[p[8*12 +: 8]];
    for (int i = 0; i < 4; i++) begin
      q[i] = p[8*i +: 8] ^ tmp[i];
    end
    for (int i = 4; i < 16; i++) begin
      q[i] = p[8*i +: 8] ^ q[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = q[i];
    end
    key_step = r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/arm_state_mem.sv -----
// Single-port-write, single-port-read 128-bit state memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arm_state_mem (
  input  wire logic              clk,
  input  wire arm_pkg::mem_req_t req,
  output logic [127:0]           rdata
);

  logic [127:0] mem [arm_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/arm_round_unit.sv -----
// Shared AES round datapath and key schedule step.
`timescale 1ns / 1ps
`default_nettype none
module arm_round_unit (
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] key_in,
  input  wire logic         mix,
  output logic [127:0]      round_out,
  input  wire logic [127:0] kexp_in,
  input  wire logic [7:0]   rcon,
  output logic [127:0]      kexp_out
);

  assign round_out = arm_pkg::aes_round(state_in, key_in, mix);
  assign kexp_out  = arm_pkg::key_step(kexp_in, rcon);

endmodule
`default_nettype wire

// ----- rtl/aes_round_mac_engine.sv -----
// Top level of the AES-round MAC engine: sequencer around the state memory and round unit.
//
//   channel | signals                                        | direction
//   input   | in_valid/in_ready, msg_word0..7, valid_bytes,  | in
//           | last_block, nonce_low, nonce_high              |
//   output  | out_valid/out_ready, tag_low, tag_high         | out
//   config  | cfg_we, cfg_index, cfg_data                    | in
//
// Every memory read takes a read state and a compute state, so one AES round takes both.
// An absorb does two folds, eight rounds and one write; a body block is taken only in idle,
// so the next block waits until the absorb of the previous one is done.
// A last block absorbs 5 or 6 blocks, then finalizes with a nonce encryption, nine word
// encryptions and a tag encryption, and loads the tag. The first block of a message first
// copies the initial words. The first message after reset or a key write first derives keys.
// Reset is synchronous; a stalled tag holds, and the next tag waits until that one is taken.
`timescale 1ns / 1ps
`default_nettype none
module aes_round_mac_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] msg_word0,
  input  wire logic [63:0] msg_word1,
  input  wire logic [63:0] msg_word2,
  input  wire logic [63:0] msg_word3,
  input  wire logic [63:0] msg_word4,
  input  wire logic [63:0] msg_word5,
  input  wire logic [63:0] msg_word6,
  input  wire logic [63:0] msg_word7,
  input  wire logic [6:0]  valid_bytes,
  input  wire logic        last_block,
  input  wire logic [63:0] nonce_low,
  input  wire logic [63:0] nonce_high,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      tag_low,
  output logic [63:0]      tag_high,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int AW = arm_pkg::ADDR_W;

  typedef enum logic [4:0] {
    S_IDLE, S_KEXP, S_ENC_RD, S_ENC_EX, S_ENC_END, S_WLD_RD, S_WLD_EX,
    S_COPY_RD, S_COPY_EX, S_ABS_A_RD, S_ABS_A_EX, S_ABS_B_RD, S_ABS_B_EX,
    S_ABS_RD, S_ABS_EX, S_ABS_W, S_DONE
  } state_t;

  typedef enum logic [1:0] {EM_DERIVE, EM_NONCE, EM_WORD, EM_TAG} enc_mode_t;
  typedef enum logic [1:0] {KX_MASTER, KX_NONCE, KX_TAG} kx_sel_t;

  state_t state;
  enc_mode_t mode;
  kx_sel_t kx_sel;

  logic [63:0] key_low, key_high;
  logic in_message, keys_derived;

  logic [511:0] blk;
  logic [127:0] nonce;
  logic last_q, pad_pend;
  logic [2:0] blanks;

  logic [127:0] acc, treg, kreg;
  logic [127:0] rr, r0, r1, r2;
  logic [7:0] rcon;
  logic [AW-1:0] base, kbase;
  logic [3:0] j, n, w, c;
  logic [4:0] ctr;
  logic [2:0] ai;

  arm_pkg::mem_req_t req;
  logic [127:0] rdata, round_out, kexp_out;
  logic [127:0] r_in, r_key, abs_key, enc_key;
  logic r_mix, enc_mix;
  logic [511:0] msg, padded;
  logic [6:0] cnt;

  // Derived words land in the initial words first, then in the final subkeys, which follow.
  function automatic logic [AW-1:0] ADDR_IW_PLUS(input logic [4:0] idx);
    ADDR_IW_PLUS = arm_pkg::ADDR_IW + AW'(idx);
  endfunction

  arm_state_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  arm_round_unit u_round (
    .state_in(r_in), .key_in(r_key), .mix(r_mix), .round_out(round_out),
    .kexp_in(kreg), .rcon(rcon), .kexp_out(kexp_out)
  );

  assign in_ready = (state == S_IDLE);

  // Pad the incoming block: valid bytes, then 0x01 and zeros if a last block is short.
  always_comb begin
    msg = {msg_word7, msg_word6, msg_word5, msg_word4,
           msg_word3, msg_word2, msg_word1, msg_word0};
    if (!last_block || valid_bytes > 7'(arm_pkg::BLOCK_BYTES)) begin
      cnt = 7'(arm_pkg::BLOCK_BYTES);
    end else begin
      cnt = valid_bytes;
    end
    for (int i = 0; i < arm_pkg::BLOCK_BYTES; i++) begin
      if (7'(i) < cnt) begin
        padded[8*i +: 8] = msg[8*i +: 8];
      end else if (7'(i) == cnt) begin
        padded[8*i +: 8] = 8'h01;
      end else begin
        padded[8*i +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    case (ai) inside
      3'd7, 3'd1, 3'd0: abs_key = blk[511:384];
      3'd6, 3'd5:       abs_key = blk[255:128];
      3'd4, 3'd3:       abs_key = blk[127:0];
      default:          abs_key = r1 ^ r2;
    endcase
    if (mode == EM_WORD && j == 4'(arm_pkg::LAST_ROUND)) begin
      enc_key = '0;
    end else begin
      enc_key = rdata;
    end
    enc_mix = !(j == 4'(arm_pkg::LAST_ROUND) && mode != EM_WORD);
    if (state == S_ABS_EX) begin
      r_in = rdata;
      r_key = abs_key;
      r_mix = 1'b1;
    end else begin
      r_in = acc;
      r_key = enc_key;
      r_mix = enc_mix;
    end
  end

  // Read and write addresses. Reads and writes of one entry never fall in the same cycle:
  // the absorb pass walks downward, writing slot i+1 after slot i+1 has been read.
  always_comb begin
    req.we = 1'b0;
    req.waddr = '0;
    req.wdata = acc;
    req.raddr = '0;
    case (state)
      S_KEXP: begin
        req.we = 1'b1;
        req.waddr = kbase + AW'(n);
        req.wdata = kreg;
      end
      S_ENC_RD:   req.raddr = base + AW'(j);
      S_ENC_END: begin
        if (mode == EM_DERIVE && ctr < 5'(arm_pkg::N_WORDS + arm_pkg::N_SUBKEYS)) begin
          req.we = 1'b1;
          req.waddr = ADDR_IW_PLUS(ctr);
        end
      end
      S_WLD_RD:   req.raddr = arm_pkg::ADDR_AS + AW'(w);
      S_COPY_RD:  req.raddr = arm_pkg::ADDR_IW + AW'(c);
      S_COPY_EX: begin
        req.we = 1'b1;
        req.waddr = arm_pkg::ADDR_AS + AW'(c);
        req.wdata = rdata;
      end
      S_ABS_A_RD: req.raddr = arm_pkg::ADDR_AS;
      S_ABS_B_RD: req.raddr = arm_pkg::ADDR_AS + AW'(arm_pkg::N_WORDS - 1);
      S_ABS_RD:   req.raddr = arm_pkg::ADDR_AS + AW'(ai);
      S_ABS_EX: begin
        req.we = 1'b1;
        req.waddr = arm_pkg::ADDR_AS + AW'(ai) + AW'(1);
        req.wdata = round_out;
      end
      S_ABS_W: begin
        req.we = 1'b1;
        req.waddr = arm_pkg::ADDR_AS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_message <= 1'b0;
      keys_derived <= 1'b0;
      out_valid <= 1'b0;
      key_low <= '0;
      key_high <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          arm_pkg::REG_KEY_LOW:  key_low <= cfg_data;
          arm_pkg::REG_KEY_HIGH: key_high <= cfg_data;
          default: ;
        endcase
        keys_derived <= 1'b0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            blk <= padded;
            nonce <= {nonce_high, nonce_low};
            last_q <= last_block;
            pad_pend <= last_block && cnt == 7'(arm_pkg::BLOCK_BYTES);
            blanks <= 3'(arm_pkg::N_BLANK);
            in_message <= 1'b1;
            c <= '0;
            if (in_message) begin
              state <= S_ABS_A_RD;
            end else if (keys_derived) begin
              state <= S_COPY_RD;
            end else begin
              kreg <= {key_high, key_low};
              kbase <= arm_pkg::ADDR_MK;
              kx_sel <= KX_MASTER;
              n <= '0;
              rcon <= 8'h01;
              state <= S_KEXP;
            end
          end
        end
        S_KEXP: begin
          kreg <= kexp_out;
          rcon <= arm_pkg::xtime(rcon);
          n <= n + 4'd1;
          if (n == 4'(arm_pkg::LAST_ROUND)) begin
            mode <= EM_DERIVE;
            base <= arm_pkg::ADDR_MK;
            j <= '0;
            case (kx_sel)
              KX_MASTER: begin
                ctr <= '0;
                acc <= '0;
                state <= S_ENC_RD;
              end
              KX_NONCE: begin
                ctr <= ctr + 5'd1;
                acc <= {123'd0, ctr + 5'd1};
                state <= S_ENC_RD;
              end
              default: begin
                keys_derived <= 1'b1;
                state <= S_COPY_RD;
              end
            endcase
          end
        end
        S_ENC_RD: state <= S_ENC_EX;
        S_ENC_EX: begin
          if (j == '0) begin
            acc <= acc ^ enc_key;
          end else begin
            acc <= round_out;
          end
          if (j == 4'(arm_pkg::LAST_ROUND)) begin
            state <= S_ENC_END;
          end else begin
            j <= j + 4'd1;
            state <= S_ENC_RD;
          end
        end
        S_ENC_END: begin
          j <= '0;
          case (mode)
            EM_DERIVE: begin
              if (ctr < 5'(arm_pkg::N_WORDS + arm_pkg::N_SUBKEYS)) begin
                ctr <= ctr + 5'd1;
                acc <= {123'd0, ctr + 5'd1};
                state <= S_ENC_RD;
              end else begin
                kreg <= acc;
                n <= '0;
                rcon <= 8'h01;
                if (ctr == 5'(arm_pkg::N_WORDS + arm_pkg::N_SUBKEYS)) begin
                  kbase <= arm_pkg::ADDR_NK;
                  kx_sel <= KX_NONCE;
                end else begin
                  kbase <= arm_pkg::ADDR_TK;
                  kx_sel <= KX_TAG;
                end
                state <= S_KEXP;
              end
            end
            EM_NONCE: begin
              treg <= nonce ^ acc;
              w <= '0;
              state <= S_WLD_RD;
            end
            EM_WORD: begin
              treg <= treg ^ acc;
              if (w == 4'(arm_pkg::N_WORDS - 1)) begin
                acc <= treg ^ acc;
                mode <= EM_TAG;
                base <= arm_pkg::ADDR_TK;
                state <= S_ENC_RD;
              end else begin
                w <= w + 4'd1;
                state <= S_WLD_RD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_WLD_RD: state <= S_WLD_EX;
        S_WLD_EX: begin
          acc <= rdata;
          mode <= EM_WORD;
          base <= arm_pkg::ADDR_FS + AW'(w);
          j <= '0;
          state <= S_ENC_RD;
        end
        S_COPY_RD: state <= S_COPY_EX;
        S_COPY_EX: begin
          c <= c + 4'd1;
          if (c == 4'(arm_pkg::N_WORDS - 1)) begin
            rr <= '0;
            r0 <= '0;
            r1 <= '0;
            r2 <= '0;
            state <= S_ABS_A_RD;
          end else begin
            state <= S_COPY_RD;
          end
        end
        S_ABS_A_RD: state <= S_ABS_A_EX;
        S_ABS_A_EX: begin
          acc <= rdata ^ blk[383:256];
          state <= S_ABS_B_RD;
        end
        S_ABS_B_RD: state <= S_ABS_B_EX;
        S_ABS_B_EX: begin
          acc <= acc ^ rdata;
          ai <= 3'(arm_pkg::N_WORDS - 2);
          state <= S_ABS_RD;
        end
        S_ABS_RD: state <= S_ABS_EX;
        S_ABS_EX: begin
          if (ai == '0) begin
            state <= S_ABS_W;
          end else begin
            ai <= ai - 3'd1;
            state <= S_ABS_RD;
          end
        end
        S_ABS_W: begin
          r2 <= r1;
          r1 <= r0;
          r0 <= rr ^ blk[255:128];
          rr <= blk[383:256];
          if (!last_q) begin
            state <= S_IDLE;
          end else if (pad_pend) begin
            pad_pend <= 1'b0;
            blk <= 512'h01;
            state <= S_ABS_A_RD;
          end else if (blanks != '0) begin
            blanks <= blanks - 3'd1;
            blk <= '0;
            state <= S_ABS_A_RD;
          end else begin
            acc <= nonce;
            mode <= EM_NONCE;
            base <= arm_pkg::ADDR_NK;
            j <= '0;
            state <= S_ENC_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            tag_low <= acc[63:0];
            tag_high <= acc[127:64];
            out_valid <= 1'b1;
            in_message <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/arm_checker.sv -----
// Port-level checks on the MAC engine and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module arm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        last_block,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] tag_low,
  input wire logic [63:0] tag_high
);

  // A stalled tag holds.
  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tag_low) && $stable(tag_high))
    else $error("tag changed while stalled");

  // A body block never yields a tag right after its transfer.
  a_no_body_tag: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_block && !out_valid |=> !out_valid)
    else $error("tag after a body block");

  // After a transfer in, the engine is busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("tag valid after reset");

endmodule

bind aes_round_mac_engine arm_checker u_arm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .last_block(last_block), .out_valid(out_valid), .out_ready(out_ready),
  .tag_low(tag_low), .tag_high(tag_high)
);
`default_nettype wire
